// ----- src/apsf_pkg.sv -----
// Shared constants, codes and types for the antialiased point splat framebuffer.
package apsf_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int DIM_W    = 7;
    localparam int FRAC_W   = 8;
    localparam int XPOS_W   = COL_W + FRAC_W;
    localparam int YPOS_W   = 15;

    localparam logic [1:0] OP_SPLAT  = 2'd0;
    localparam logic [1:0] OP_FADE   = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BRIGHT = 2'd2;

    localparam logic [7:0] FADE_GAIN = 8'd237;
    localparam int         HUE_SPAN  = 43;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] val;
    } t_cell;

endpackage

// ----- src/apsf_rem.sv -----
// Bit-serial restoring remainder of a column index by the active frame width.
module apsf_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [apsf_pkg::COL_W-1:0]  i_dividend,
    input  logic [apsf_pkg::DIM_W-1:0]  i_modulus,
    output logic                        o_done,
    output logic [apsf_pkg::DIM_W-1:0]  o_rem
);
    import apsf_pkg::*;

    localparam int CNT_W = $clog2(COL_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [COL_W-1:0]  r_num;
    logic [DIM_W-1:0]  r_rem;
    logic [DIM_W-1:0]  r_mod;
    logic [DIM_W-1:0]  n_trial;
    logic [DIM_W-1:0]  n_rem;

    always_comb begin
        n_trial = {r_rem[DIM_W-2:0], r_num[COL_W-1]};
        n_rem   = (n_trial >= r_mod) ? n_trial - r_mod : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_mod <= i_modulus;
        end else if (r_busy) begin
            r_num <= {r_num[COL_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- src/antialiased_point_splat_framebuffer.sv -----
// Top level: hue/value framebuffer with splat, fade and render commands.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------------------------
//  command  | in        | i_in_valid / o_in_stall   | operation, x/y pos, brightness, hue, pixel
//  pixel    | out       | o_out_valid / i_out_stall | red, green, blue
//  config   | in        | psel/penable/pwrite       | paddr, pwdata, prdata, pready
//
// One transaction is handled at a time by a shared 8x8 multiplier under a sequencer.
// A splat first finds the column-wrap remainder, then visits four cells through the states SP_W1, SP_W2, SP_W3.
// A fade reads, scales and writes back each active cell in turn; a render skips the hue conversion when the
// scaled value is zero and goes straight to the output when the pixel lies outside the active frame.
// After reset a clearing pass writes all 4096 cells, one per cycle, with o_in_stall high.
// A finished render waits in the output register, so a stalled output blocks only a later render.
module antialiased_point_splat_framebuffer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_operation,
    input  logic [apsf_pkg::XPOS_W-1:0]  i_x_pos,
    input  logic signed [apsf_pkg::YPOS_W-1:0] i_y_pos,
    input  logic [7:0]                   i_splat_brightness,
    input  logic [7:0]                   i_splat_hue,
    input  logic [apsf_pkg::COL_W-1:0]   i_pixel_col,
    input  logic [apsf_pkg::ROW_W-1:0]   i_pixel_row,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import apsf_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CLEAR  = 4'd1;
    localparam logic [3:0] ST_MOD    = 4'd2;
    localparam logic [3:0] ST_SP_W1  = 4'd3;
    localparam logic [3:0] ST_SP_W2  = 4'd4;
    localparam logic [3:0] ST_SP_W3  = 4'd5;
    localparam logic [3:0] ST_FD_RD  = 4'd6;
    localparam logic [3:0] ST_FD_MUL = 4'd7;
    localparam logic [3:0] ST_FD_WR  = 4'd8;
    localparam logic [3:0] ST_RD_RD  = 4'd9;
    localparam logic [3:0] ST_RD_MUL = 4'd10;
    localparam logic [3:0] ST_RD_DIV = 4'd11;
    localparam logic [3:0] ST_RD_Q   = 4'd12;
    localparam logic [3:0] ST_RD_T   = 4'd13;
    localparam logic [3:0] ST_RD_SEL = 4'd14;
    localparam logic [3:0] ST_RD_OUT = 4'd15;

    t_cell mem [CELLS];

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [7:0]        r_bright;
    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic [1:0]        r_k;
    logic [1:0]        n_k;
    logic [COL_W-1:0]  r_px0;
    logic [7:0]        r_row0;
    logic [7:0]        r_xx;
    logic [7:0]        r_yy;
    logic [7:0]        r_sbri;
    logic [7:0]        r_shue;
    logic [15:0]       r_prod;
    logic [7:0]        r_hue;
    logic [7:0]        r_v;
    logic [7:0]        r_q;
    logic [7:0]        r_res_r;
    logic [7:0]        r_res_g;
    logic [7:0]        r_res_b;
    logic [7:0]        n_res_r;
    logic [7:0]        n_res_g;
    logic [7:0]        n_res_b;
    logic              r_out_valid;
    logic [7:0]        r_out_r;
    logic [7:0]        r_out_g;
    logic [7:0]        r_out_b;
    t_cell             r_rdata;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              in_acc;
    logic              cfg_wr;
    logic              rem_start;
    logic              rem_done;
    logic [DIM_W-1:0]  rem;
    logic [DIM_W-1:0]  px_inc;
    logic [COL_W-1:0]  px_k;
    logic [7:0]        row_k;
    logic              row_ok;
    logic [ADDR_W-1:0] cell_addr;
    logic [7:0]        wa;
    logic [7:0]        wb;
    logic [16:0]       wsum;
    logic [16:0]       divsum;
    logic [2:0]        region;
    logic [7:0]        sector_base;
    logic [7:0]        frac;
    logic [7:0]        qf;
    logic [7:0]        tf;
    logic [7:0]        mul_a;
    logic [7:0]        mul_b;
    logic              mul_en;
    logic [15:0]       mul_p;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    t_cell             mem_wdata;
    logic              out_load;
    logic              render_in;
    logic [7:0]        fx;
    logic [7:0]        fy;

    always_comb begin
        if (r_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_COLS)) begin
            w_eff = DIM_W'(MAX_COLS);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_ROWS)) begin
            h_eff = DIM_W'(MAX_ROWS);
        end else begin
            h_eff = r_height;
        end
    end

    assign in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign rem_start = in_acc && (i_operation == OP_SPLAT);
    assign render_in = ({1'b0, i_pixel_col} < w_eff) && ({1'b0, i_pixel_row} < h_eff);
    assign fx        = i_x_pos[FRAC_W-1:0];
    assign fy        = i_y_pos[FRAC_W-1:0];

    apsf_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (i_x_pos[XPOS_W-1:FRAC_W]),
        .i_modulus  (w_eff),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    always_comb begin
        px_inc    = {1'b0, r_px0} + DIM_W'(1);
        px_k      = r_k[0] ? ((px_inc == w_eff) ? '0 : px_inc[COL_W-1:0]) : r_px0;
        row_k     = r_row0 + {7'd0, r_k[1]};
        row_ok    = !row_k[7] && (row_k[DIM_W-1:0] < h_eff);
        cell_addr = {px_k, row_k[ROW_W-1:0]};
        wa        = r_k[0] ? r_xx : ~r_xx;
        wb        = r_k[1] ? r_yy : ~r_yy;
        wsum      = {1'b0, r_prod} + {9'd0, wa} + {9'd0, wb};
        divsum    = {1'b0, r_prod} + 17'd1 + {9'd0, r_prod[15:8]};
    end

    always_comb begin
        region      = 3'd0;
        sector_base = 8'd0;
        for (int i = 1; i < 6; i++) begin
            if (r_hue >= 8'(i * HUE_SPAN)) begin
                region      = 3'(i);
                sector_base = 8'(i * HUE_SPAN);
            end
        end
        frac = 8'(r_hue - sector_base) * 8'd6;
        qf   = (frac == 8'd0) ? 8'd255 : 8'(9'd256 - {1'b0, frac});
        tf   = frac + 8'd1;
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_k       = r_k;
        n_res_r   = r_res_r;
        n_res_g   = r_res_g;
        n_res_b   = r_res_b;
        mul_en    = 1'b0;
        mul_a     = r_rdata.val;
        mul_b     = r_bright;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_operation)
                        OP_SPLAT: begin
                            n_k     = 2'd0;
                            n_state = ST_MOD;
                        end
                        OP_FADE: begin
                            n_addr  = '0;
                            n_state = ST_FD_RD;
                        end
                        OP_RENDER: begin
                            n_addr = {i_pixel_col, i_pixel_row};
                            if (render_in) begin
                                n_state = ST_RD_RD;
                            end else begin
                                n_res_r = '0;
                                n_res_g = '0;
                                n_res_b = '0;
                                n_state = ST_RD_OUT;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MOD: begin
                if (rem_done) begin
                    n_state = ST_SP_W1;
                end
            end
            ST_SP_W1: begin
                mul_en  = 1'b1;
                mul_a   = wa;
                mul_b   = wb;
                n_state = ST_SP_W2;
            end
            ST_SP_W2: begin
                mul_en  = 1'b1;
                mul_a   = r_sbri;
                mul_b   = wsum[15:8];
                n_state = ST_SP_W3;
            end
            ST_SP_W3: begin
                mem_waddr = cell_addr;
                mem_wdata = '{hue: r_shue, val: r_prod[15:8]};
                mem_we    = row_ok && (r_prod[15:8] >= r_rdata.val);
                n_k       = r_k + 1'b1;
                n_state   = (r_k == 2'd3) ? ST_IDLE : ST_SP_W1;
            end
            ST_FD_RD: begin
                n_state = ST_FD_MUL;
            end
            ST_FD_MUL: begin
                mul_en  = 1'b1;
                mul_b   = FADE_GAIN;
                n_state = ST_FD_WR;
            end
            ST_FD_WR: begin
                mem_we    = 1'b1;
                mem_wdata = '{hue: r_rdata.hue, val: r_prod[15:8]};
                n_state   = ST_FD_RD;
                if ({1'b0, r_addr[ROW_W-1:0]} + DIM_W'(1) != h_eff) begin
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_addr = {r_addr[ADDR_W-1:ROW_W] + 1'b1, {ROW_W{1'b0}}};
                    if ({1'b0, r_addr[ADDR_W-1:ROW_W]} + DIM_W'(1) == w_eff) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RD_RD: begin
                n_state = ST_RD_MUL;
            end
            ST_RD_MUL: begin
                mul_en  = 1'b1;
                n_state = ST_RD_DIV;
            end
            ST_RD_DIV: begin
                if (divsum[15:8] == 8'd0) begin
                    n_res_r = '0;
                    n_res_g = '0;
                    n_res_b = '0;
                    n_state = ST_RD_OUT;
                end else begin
                    n_state = ST_RD_Q;
                end
            end
            ST_RD_Q: begin
                mul_en  = 1'b1;
                mul_a   = r_v;
                mul_b   = qf;
                n_state = ST_RD_T;
            end
            ST_RD_T: begin
                mul_en  = 1'b1;
                mul_a   = r_v;
                mul_b   = tf;
                n_state = ST_RD_SEL;
            end
            ST_RD_SEL: begin
                case (region)
                    3'd0: begin n_res_r = r_v; n_res_g = r_prod[15:8]; n_res_b = '0; end
                    3'd1: begin n_res_r = r_q; n_res_g = r_v; n_res_b = '0; end
                    3'd2: begin n_res_r = '0; n_res_g = r_v; n_res_b = r_prod[15:8]; end
                    3'd3: begin n_res_r = '0; n_res_g = r_q; n_res_b = r_v; end
                    3'd4: begin n_res_r = r_prod[15:8]; n_res_g = '0; n_res_b = r_v; end
                    default: begin n_res_r = r_v; n_res_g = '0; n_res_b = r_q; end
                endcase
                n_state = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign mem_raddr = (r_state == ST_SP_W1 || r_state == ST_SP_W2 || r_state == ST_SP_W3)
                       ? cell_addr : r_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= DIM_W'(64);
            r_height    <= DIM_W'(64);
            r_bright    <= 8'd220;
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                    REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                    REG_BRIGHT: r_bright <= pwdata[7:0];
                    default:    r_bright <= r_bright;
                endcase
            end
            r_state <= n_state;
            r_addr  <= n_addr;
            r_k     <= n_k;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rem_start) begin
            r_row0 <= {i_y_pos[YPOS_W-1], i_y_pos[YPOS_W-1:FRAC_W]};
            r_xx   <= (fx == 8'd0) ? 8'd0 : fx - 8'd1;
            r_yy   <= (fy == 8'd0) ? 8'd0 : fy - 8'd1;
            r_sbri <= i_splat_brightness;
            r_shue <= i_splat_hue;
        end
        if (r_state == ST_MOD && rem_done) begin
            r_px0 <= rem[COL_W-1:0];
        end
        if (mul_en) begin
            r_prod <= mul_p;
        end
        if (r_state == ST_RD_MUL) begin
            r_hue <= r_rdata.hue;
        end
        if (r_state == ST_RD_DIV) begin
            r_v <= divsum[15:8];
        end
        if (r_state == ST_RD_T) begin
            r_q <= r_prod[15:8];
        end
        r_res_r <= n_res_r;
        r_res_g <= n_res_g;
        r_res_b <= n_res_b;
        if (out_load) begin
            r_out_r <= r_res_r;
            r_out_g <= r_res_g;
            r_out_b <= r_res_b;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {25'd0, r_width};
            REG_HEIGHT: prdata = {25'd0, r_height};
            REG_BRIGHT: prdata = {24'd0, r_bright};
            default:    prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_red       = r_out_r;
    assign o_green     = r_out_g;
    assign o_blue      = r_out_b;

    a_fade_no_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FD_WR) |-> (mem_wdata.val <= r_rdata.val))
        else $error("fade raised a cell value");

    a_wrap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD && rem_done) |-> (rem < w_eff))
        else $error("column remainder not below the active width");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD_OUT && r_out_valid && i_out_stall) |=> (r_state == ST_RD_OUT))
        else $error("render result dropped while the output was stalled");

endmodule

// ----- verif/antialiased_point_splat_framebuffer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the point splat framebuffer with a framebuffer predictor.
module antialiased_point_splat_framebuffer_tb;
    import apsf_pkg::*;

    localparam logic [1:0] OP_IDLE = 2'd3;
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 163;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct {
        logic [1:0]                op;
        logic [XPOS_W-1:0]         x;
        logic signed [YPOS_W-1:0]  y;
        logic [7:0]                bright;
        logic [7:0]                hue;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        bit                        black;
    } t_command;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [1:0]                  i_operation;
    logic [XPOS_W-1:0]           i_x_pos;
    logic signed [YPOS_W-1:0]    i_y_pos;
    logic [7:0]                  i_splat_brightness;
    logic [7:0]                  i_splat_hue;
    logic [COL_W-1:0]            i_pixel_col;
    logic [ROW_W-1:0]            i_pixel_row;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [7:0]                  o_red;
    logic [7:0]                  o_green;
    logic [7:0]                  o_blue;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [3:0]                  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    logic [7:0]       hue_cells [CELLS];
    logic [7:0]       value_cells [CELLS];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [7:0]       bright_reg;
    t_rgb             pixel_q [$];
    t_command         directed_q [$];

    int  errors = 0;
    int  cycle_count = 0;
    int  n_splat = 0;
    int  n_fade = 0;
    int  n_render = 0;
    int  n_lit = 0;
    int  n_cfg = 0;
    int  last_col = 0;
    int  last_row = 0;
    bit  calm = 1'b0;

    int phase_w [PHASES] = '{64, 1, 64, 0, 127, 8, 33, 64, 2, 13};
    int phase_h [PHASES] = '{64, 1, 64, 0, 100, 5, 17, 3, 64, 64};
    int phase_b [PHASES] = '{220, 1, 255, 128, 37, 200, 90, 255, 150, 180};

    antialiased_point_splat_framebuffer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_x_pos            (i_x_pos),
        .i_y_pos            (i_y_pos),
        .i_splat_brightness (i_splat_brightness),
        .i_splat_hue        (i_splat_hue),
        .i_pixel_col        (i_pixel_col),
        .i_pixel_row        (i_pixel_row),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_red              (o_red),
        .o_green            (o_green),
        .o_blue             (o_blue),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clamp_dim(logic [DIM_W-1:0] d, int top);
        if (d < 1) return 1;
        if (d > top) return top;
        return int'(d);
    endfunction

    function automatic int frame_cols();
        return clamp_dim(width_reg, MAX_COLS);
    endfunction

    function automatic int frame_rows();
        return clamp_dim(height_reg, MAX_ROWS);
    endfunction

    function automatic void splat_cells(t_command c);
        int cols, rows, col0, row0, ys, fx, fy, xx, yy, ixx, iyy, px, py, lvl, idx, k;
        int wt [4];
        cols = frame_cols();
        rows = frame_rows();
        ys = int'(c.y);
        col0 = int'(c.x) >> FRAC_W;
        row0 = ys >>> FRAC_W;
        fx = int'(c.x) & 255;
        fy = ys & 255;
        xx = (fx * 255) >> 8;
        yy = (fy * 255) >> 8;
        ixx = 255 - xx;
        iyy = 255 - yy;
        wt[0] = (ixx * iyy + ixx + iyy) >> 8;
        wt[1] = (xx * iyy + xx + iyy) >> 8;
        wt[2] = (ixx * yy + ixx + yy) >> 8;
        wt[3] = (xx * yy + xx + yy) >> 8;
        for (k = 0; k < 4; k++) begin
            px = (col0 + (k & 1)) % cols;
            py = row0 + (k >> 1);
            if (py >= 0 && py < rows) begin
                lvl = (int'(c.bright) * wt[k]) >> 8;
                idx = px * MAX_ROWS + py;
                if (lvl >= int'(value_cells[idx])) begin
                    hue_cells[idx] = c.hue;
                    value_cells[idx] = 8'(lvl);
                end
            end
        end
    endfunction

    function automatic void fade_frame();
        int cols, rows, idx, lvl, cc, rr;
        cols = frame_cols();
        rows = frame_rows();
        for (cc = 0; cc < cols; cc++) begin
            for (rr = 0; rr < rows; rr++) begin
                idx = cc * MAX_ROWS + rr;
                lvl = (int'(value_cells[idx]) * int'(FADE_GAIN)) >> 8;
                value_cells[idx] = 8'(lvl);
            end
        end
    endfunction

    function automatic t_rgb render_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        int idx, v, hue, region, frac, q, t;
        t_rgb p;
        p = '0;
        if (int'(col) < frame_cols() && int'(row) < frame_rows()) begin
            idx = int'(col) * MAX_ROWS + int'(row);
            v = int'(value_cells[idx]) * int'(bright_reg) / 255;
            if (v >= 1) begin
                hue = int'(hue_cells[idx]);
                region = hue / HUE_SPAN;
                frac = (hue - region * HUE_SPAN) * 6;
                q = (v * (255 - ((255 * frac) >> 8))) >> 8;
                t = (v * (255 - ((255 * (255 - frac)) >> 8))) >> 8;
                case (region)
                    0: p = '{8'(v), 8'(t), 8'd0};
                    1: p = '{8'(q), 8'(v), 8'd0};
                    2: p = '{8'd0, 8'(v), 8'(t)};
                    3: p = '{8'd0, 8'(q), 8'(v)};
                    4: p = '{8'(t), 8'd0, 8'(v)};
                    default: p = '{8'(v), 8'd0, 8'(q)};
                endcase
            end
        end
        return p;
    endfunction

    function automatic void add_row(logic [1:0] op, int x, int y, int b, int h,
                                    int col, int row, bit black);
        t_command c;
        c.op = op;
        c.x = XPOS_W'(x);
        c.y = YPOS_W'(y);
        c.bright = 8'(b);
        c.hue = 8'(h);
        c.col = COL_W'(col);
        c.row = ROW_W'(row);
        c.black = black;
        directed_q.push_back(c);
    endfunction

    function automatic t_command random_command();
        t_command c;
        int cols, rows, pick, r0;
        cols = frame_cols();
        rows = frame_rows();
        c.black = 1'b0;
        c.x = XPOS_W'($urandom_range(0, 16383));
        if ($urandom_range(0, 99) < 80)
            c.y = YPOS_W'($urandom_range(0, rows * 256 + 255) - 256);
        else
            c.y = YPOS_W'($urandom_range(0, 16639) - 256);
        c.bright = 8'($urandom_range(0, 255));
        c.hue = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            c.col = COL_W'(last_col);
            c.row = ROW_W'(last_row);
        end else if (pick < 80) begin
            c.col = COL_W'($urandom_range(0, cols - 1));
            c.row = ROW_W'($urandom_range(0, rows - 1));
        end else begin
            c.col = COL_W'($urandom_range(0, 63));
            c.row = ROW_W'($urandom_range(0, 63));
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) c.op = OP_FADE;
        else if (pick < 6) c.op = OP_IDLE;
        else if (pick < 56) c.op = OP_SPLAT;
        else c.op = OP_RENDER;
        if (c.op == OP_SPLAT) begin
            last_col = (int'(c.x) >> FRAC_W) % cols;
            r0 = int'(c.y) >>> FRAC_W;
            last_row = (r0 < 0) ? 0 : ((r0 >= rows) ? rows - 1 : r0);
        end
        return c;
    endfunction

    task automatic apb_write(logic [1:0] index, logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {index, 2'b00};
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (index)
            REG_WIDTH:  width_reg = data[DIM_W-1:0];
            REG_HEIGHT: height_reg = data[DIM_W-1:0];
            REG_BRIGHT: bright_reg = data[7:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic pace();
        while (!calm && $urandom_range(0, 99) < 35) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic issue(t_command c);
        t_rgb p;
        i_in_valid = 1'b1;
        i_operation = c.op;
        i_x_pos = c.x;
        i_y_pos = c.y;
        i_splat_brightness = c.bright;
        i_splat_hue = c.hue;
        i_pixel_col = c.col;
        i_pixel_row = c.row;
        do @(posedge i_clk); while (o_in_stall);
        case (c.op)
            OP_SPLAT: begin
                splat_cells(c);
                n_splat++;
            end
            OP_FADE: begin
                fade_frame();
                n_fade++;
            end
            OP_RENDER: begin
                p = c.black ? t_rgb'('0) : render_pixel(c.col, c.row);
                pixel_q.push_back(p);
                n_render++;
                if (p != '0) n_lit++;
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Waits for every pending pixel, then, when settle is set, long enough for a full-frame fade to finish.
    task automatic drain(bit settle);
        i_in_valid = 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        if (settle) repeat (3 * frame_cols() * frame_rows() + 64) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall = !calm && ($urandom_range(0, 99) < 35);
    end

    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual %0d/%0d/%0d",
                         $time, o_red, o_green, o_blue);
                errors++;
            end else begin
                want = pixel_q.pop_front();
                if (o_red !== want.red) begin
                    $display("%0t: red expected %0d actual %0d", $time, want.red, o_red);
                    errors++;
                end
                if (o_green !== want.green) begin
                    $display("%0t: green expected %0d actual %0d", $time, want.green, o_green);
                    errors++;
                end
                if (o_blue !== want.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $time, want.blue, o_blue);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("FAIL antialiased_point_splat_framebuffer");
            $finish;
        end
    end

    initial begin
        t_command c;
        int done, ph;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = OP_SPLAT;
        i_x_pos = '0;
        i_y_pos = '0;
        i_splat_brightness = '0;
        i_splat_hue = '0;
        i_pixel_col = '0;
        i_pixel_row = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        width_reg = 7'd64;
        height_reg = 7'd64;
        bright_reg = 8'd220;
        for (int i = 0; i < CELLS; i++) begin
            hue_cells[i] = '0;
            value_cells[i] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        add_row(OP_RENDER, 0, 0, 0, 0, 0, 0, 1'b1);
        add_row(OP_RENDER, 0, 0, 0, 0, 63, 63, 1'b1);
        add_row(OP_IDLE, 16383, -1, 255, 255, 63, 63, 1'b0);
        add_row(OP_SPLAT, 0, 0, 255, 0, 0, 0, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SPLAT, 16383, 16383, 255, 255, 0, 0, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 63, 63, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 0, 63, 1'b0);
        add_row(OP_SPLAT, 'h0A80, -256, 200, 43, 0, 0, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 10, 0, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 11, 0, 1'b0);
        add_row(OP_SPLAT, 'h0A80, -256, 10, 200, 0, 0, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 10, 0, 1'b0);
        add_row(OP_SPLAT, 20 << 8, 20 << 8, 255, 86, 0, 0, 1'b0);
        add_row(OP_SPLAT, 30 << 8, 30 << 8, 255, 129, 0, 0, 1'b0);
        add_row(OP_SPLAT, 40 << 8, 40 << 8, 255, 172, 0, 0, 1'b0);
        add_row(OP_SPLAT, 50 << 8, 50 << 8, 255, 215, 0, 0, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 20, 20, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 30, 30, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 40, 40, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 50, 50, 1'b0);
        add_row(OP_FADE, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 20, 20, 1'b0);
        add_row(OP_SPLAT, 5 << 8, 5 << 8, 0, 7, 0, 0, 1'b0);
        add_row(OP_RENDER, 0, 0, 0, 0, 5, 5, 1'b1);
        foreach (directed_q[i]) begin
            pace();
            issue(directed_q[i]);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain(1'b1);
                apb_write(REG_WIDTH, phase_w[ph]);
                apb_write(REG_HEIGHT, phase_h[ph]);
                apb_write(REG_BRIGHT, phase_b[ph]);
                if (ph == 5) apb_write(REG_SPARE, 32'hFFFF_FFFF);
            end
            calm = (ph == 6);
            done = 0;
            while (done < PHASE_ITEMS) begin
                c = random_command();
                pace();
                issue(c);
                if (c.op != OP_IDLE) begin
                    done++;
                    if (done == 40 || $urandom_range(0, 199) == 0) drain(1'b0);
                end
            end
        end
        calm = 1'b0;
        drain(1'b1);

        $display("Covered %0d splats, %0d fades and %0d renders (%0d lit) over %0d frames.",
                 n_splat, n_fade, n_render, n_lit, PHASES);
        $display("Made %0d register writes, clamped sizes and an unmapped register included.",
                 n_cfg);
        if (errors == 0) begin
            $display("PASS antialiased_point_splat_framebuffer");
        end else begin
            $display("FAIL antialiased_point_splat_framebuffer");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/apsf_pkg.sv
src/apsf_rem.sv
src/antialiased_point_splat_framebuffer.sv
verif/antialiased_point_splat_framebuffer_tb.sv
